FILE: rtl/stks_pkg.sv
// Shared types and fixed widths of the sorted table key search block.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package stks_pkg;

    localparam int KEY_W       = 64;
    localparam int DATA_W      = 16;
    localparam int IDX_W       = 12;
    localparam int SIZE_W      = 13;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 48;

    // action codes carried on the slave-side tuser
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // one table entry as stored in memory
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] weight;
        logic [DATA_W-1:0] payload;
    } t_entry;

endpackage

FILE: rtl/stks_table.sv
// Table memory of the key search: one write port, one read port, registered read data.
// Depends on stks_pkg for the entry type.
`timescale 1ns / 1ps

module stks_table #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  stks_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output stks_pkg::t_entry o_rdata
);
    import stks_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sorted_table_key_search.sv
// Sorted table key search: lower-bound bisection over a table held in one memory.
// A write request is acknowledged in the output register in the cycle after it is taken;
// a search reads one table entry per bisection step over the table size in use, then
// reads the final entry and reports once the result slot frees.
// Throughput: one request at a time; a new request is taken once the result slot frees.
// Reset (i_rst_n, synchronous, active low) clears control and table_size; contents do not.
`timescale 1ns / 1ps

module sorted_table_key_search #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration: table_size
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [stks_pkg::SIZE_W-1:0]     i_cfg_data,
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // from bit 0: entry_index[11:0], key[75:12], entry_payload[91:76],
    // entry_weight[107:92], zero fill[111:108]
    input  logic [stks_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // action: 0 write, 1 search
    input  logic                            s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // from bit 0: match_index[12:0], match_payload[28:13], match_weight[44:29],
    // zero fill[47:45]
    output logic [stks_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // found
    output logic                            m_axis_tuser
);
    import stks_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // request fields
    logic [IDX_W-1:0]  req_index;
    logic [KEY_W-1:0]  req_key;
    logic [DATA_W-1:0] req_payload;
    logic [DATA_W-1:0] req_weight;
    logic              req_accept;

    // control state
    logic [1:0]        r_state, n_state;
    logic [SIZE_W-1:0] r_table_size;
    logic [SIZE_W-1:0] r_lo, n_lo;
    logic [SIZE_W-1:0] r_hi, n_hi;
    logic [SIZE_W-1:0] r_mid, n_mid;
    logic              r_pend, n_pend;
    logic              r_ovalid, n_ovalid;

    // search operands and result payload
    logic [KEY_W-1:0]  r_key, n_key;
    logic [SIZE_W-1:0] r_n, n_n;
    logic              r_ofound, n_ofound;
    logic [SIZE_W-1:0] r_oindex, n_oindex;
    logic [DATA_W-1:0] r_opayload, n_opayload;
    logic [DATA_W-1:0] r_oweight, n_oweight;

    // bisection step
    logic [SIZE_W-1:0] size_eff;
    logic              key_le;
    logic [SIZE_W-1:0] step_lo;
    logic [SIZE_W-1:0] step_hi;
    logic [SIZE_W-1:0] step_mid;
    logic              out_free;

    // memory port
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    t_entry            mem_wdata;
    t_entry            mem_rdata;

    assign req_index   = s_axis_tdata[11:0];
    assign req_key     = s_axis_tdata[75:12];
    assign req_payload = s_axis_tdata[91:76];
    assign req_weight  = s_axis_tdata[107:92];

    // the user must write config only while idle; the block does not enforce it and always takes them
    assign o_cfg_ready = 1'b1;

    // result slot is free when empty or being drained this cycle
    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign req_accept    = s_axis_tvalid && s_axis_tready;

    // saturate table_size to the memory depth
    assign size_eff = (32'(r_table_size) > 32'(TABLE_DEPTH)) ? SIZE_W'(TABLE_DEPTH)
                                                             : r_table_size;

    // write: drop indexes beyond the memory
    assign mem_we    = req_accept && (s_axis_tuser == ACT_WRITE)
                       && (32'(req_index) < 32'(TABLE_DEPTH));
    assign mem_waddr = AW'(req_index);
    assign mem_wdata = '{key: req_key, weight: req_weight, payload: req_payload};

    // fold in the compare of the read in flight, then pick the next probe
    assign key_le = r_key <= mem_rdata.key;

    always_comb begin
        if (r_pend) begin
            if (key_le) begin
                step_lo = r_lo;
                step_hi = r_mid;
            end else begin
                step_lo = r_mid + SIZE_W'(1);
                step_hi = r_hi;
            end
        end else begin
            step_lo = r_lo;
            step_hi = r_hi;
        end
        step_mid = step_lo + ((step_hi - step_lo) >> 1);
    end

    // read address: next probe while bisecting, final entry otherwise
    always_comb begin
        if ((r_state == ST_RUN) && (step_lo < step_hi)) begin
            mem_raddr = AW'(step_mid);
        end else if (r_state == ST_RUN) begin
            mem_raddr = AW'(step_lo);
        end else begin
            mem_raddr = AW'(r_lo);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_pend     = r_pend;
        n_key      = r_key;
        n_n        = r_n;
        n_ovalid   = r_ovalid && !m_axis_tready;
        n_ofound   = r_ofound;
        n_oindex   = r_oindex;
        n_opayload = r_opayload;
        n_oweight  = r_oweight;

        unique case (r_state)
            ST_IDLE: begin
                if (req_accept) begin
                    if ((s_axis_tuser == ACT_SEARCH) && (size_eff != '0)) begin
                        // start bisection over [0, n-1]
                        n_state = ST_RUN;
                        n_key   = req_key;
                        n_n     = size_eff;
                        n_lo    = '0;
                        n_hi    = size_eff - SIZE_W'(1);
                        n_pend  = 1'b0;
                    end else begin
                        // write acknowledge, or not found in an empty table
                        n_ovalid   = 1'b1;
                        n_ofound   = 1'b0;
                        n_oindex   = (s_axis_tuser == ACT_SEARCH) ? size_eff : '0;
                        n_opayload = '0;
                        n_oweight  = '0;
                    end
                end
            end
            ST_RUN: begin
                n_lo = step_lo;
                n_hi = step_hi;
                if (step_lo < step_hi) begin
                    n_mid  = step_mid;
                    n_pend = 1'b1;
                end else begin
                    // range closed: final entry read issued this cycle
                    n_pend  = 1'b0;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold the read address until the result slot frees
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                    if (mem_rdata.key == r_key) begin
                        n_ofound   = 1'b1;
                        n_oindex   = r_lo;
                        n_opayload = mem_rdata.payload;
                        n_oweight  = mem_rdata.weight;
                    end else begin
                        n_ofound   = 1'b0;
                        n_oindex   = r_n;
                        n_opayload = '0;
                        n_oweight  = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_table_size <= '0;
            r_lo         <= '0;
            r_hi         <= '0;
            r_mid        <= '0;
            r_pend       <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_mid    <= n_mid;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_table_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_n        <= n_n;
        r_ofound   <= n_ofound;
        r_oindex   <= n_oindex;
        r_opayload <= n_opayload;
        r_oweight  <= n_oweight;
    end

    stks_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ofound;
    assign m_axis_tdata  = {3'b000, r_oweight, r_opayload, r_oindex};

    // bisection range never inverts
    a_range_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_lo <= r_hi))
        else $error("bisection range inverted");

    // final read stays inside the table in use
    a_final_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (r_lo < r_n))
        else $error("final read beyond table size");

    // a probe in flight only exists while bisecting
    a_pend_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> !r_pend)
        else $error("read pending outside bisection");

    // a reported match lies below the table size in use
    a_found_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (r_oindex < size_eff))
        else $error("match index beyond table size");

endmodule

FILE: dv/stks_scoreboard_pkg.sv
// Result checker for the sorted table key search testbench: a table mirror with a
// lower-bound predictor and an in-order store of expected results.
// Depends on stks_pkg for field widths and action codes.
`timescale 1ns / 1ps

package stks_scoreboard_pkg;

    import stks_pkg::*;

    localparam int MIRROR_DEPTH = 4096;

    typedef struct packed {
        logic              found;
        logic [SIZE_W-1:0] index;
        logic [DATA_W-1:0] payload;
        logic [DATA_W-1:0] weight;
    } t_match;

    class search_scoreboard;
        logic [KEY_W-1:0]  key_mem     [MIRROR_DEPTH];
        logic [DATA_W-1:0] payload_mem [MIRROR_DEPTH];
        logic [DATA_W-1:0] weight_mem  [MIRROR_DEPTH];
        bit                written_mem [MIRROR_DEPTH];
        int unsigned       table_size;
        t_match            expected_matches[$];
        int unsigned       errors;
        int unsigned       results;
        int unsigned       writes;
        int unsigned       searches;
        int unsigned       hits;

        function new();
            table_size = 0;
            errors     = 0;
            results    = 0;
            writes     = 0;
            searches   = 0;
            hits       = 0;
        endfunction

        function void set_table_size(int unsigned value);
            table_size = value & 32'h1FFF;
        endfunction

        // saturate to the table depth
        function int unsigned effective_size();
            return (table_size > MIRROR_DEPTH) ? MIRROR_DEPTH : table_size;
        endfunction

        function int unsigned pending();
            return expected_matches.size();
        endfunction

        // true when the bisection for this key reads only entries written since reset
        function bit path_written(logic [KEY_W-1:0] sought);
            int unsigned n;
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            n = effective_size();
            if (n == 0) begin
                return 1'b1;
            end
            lo = 0;
            hi = n - 1;
            while (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (!written_mem[mid]) begin
                    return 1'b0;
                end
                if (sought <= key_mem[mid]) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
            return written_mem[lo];
        endfunction

        // lowest index whose key is not below the sought key, then an equality test
        function t_match lower_bound_lookup(logic [KEY_W-1:0] sought);
            t_match      res;
            int unsigned n;
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            res = '0;
            n   = effective_size();
            if (n == 0) begin
                return res;
            end
            lo = 0;
            hi = n - 1;
            while (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (sought <= key_mem[mid]) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
            if (key_mem[lo] == sought) begin
                res.found   = 1'b1;
                res.index   = SIZE_W'(lo);
                res.payload = payload_mem[lo];
                res.weight  = weight_mem[lo];
            end else begin
                res.index = SIZE_W'(n);
            end
            return res;
        endfunction

        function void note_request(logic act, logic [IDX_W-1:0] idx, logic [KEY_W-1:0] key,
                                   logic [DATA_W-1:0] payload, logic [DATA_W-1:0] weight);
            t_match want;
            if (act == ACT_WRITE) begin
                key_mem[idx]     = key;
                payload_mem[idx] = payload;
                weight_mem[idx]  = weight;
                written_mem[idx] = 1'b1;
                writes++;
                want = '0;
                expected_matches.push_back(want);
            end else begin
                want = lower_bound_lookup(key);
                searches++;
                if (want.found) begin
                    hits++;
                end
                expected_matches.push_back(want);
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic found, logic [OUT_TDATA_W-1:0] tdata);
            t_match want;
            results++;
            if (expected_matches.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual found=%0b tdata=%0h",
                         $time, found, tdata);
                return;
            end
            want = expected_matches.pop_front();
            compare_field("found", 64'(want.found), 64'(found));
            compare_field("match_index", 64'(want.index), 64'(tdata[12:0]));
            compare_field("match_payload", 64'(want.payload), 64'(tdata[28:13]));
            compare_field("match_weight", 64'(want.weight), 64'(tdata[44:29]));
            compare_field("tdata fill", 64'(0), 64'(tdata[47:45]));
        endfunction

        function void flag_leftovers();
            if (expected_matches.size() != 0) begin
                errors++;
                $display("%0t: %0d results never arrived, expected %0h actual none",
                         $time, expected_matches.size(), expected_matches[0]);
            end
        endfunction
    endclass

endpackage

FILE: dv/tb_top.sv
// Top-level testbench of sorted_table_key_search: drives writes, searches and table_size
// settings with random idling and checks every result in order.
// Depends on stks_pkg, stks_scoreboard_pkg and the sorted_table_key_search RTL.
`timescale 1ns / 1ps

module tb_top;

    import stks_pkg::*;
    import stks_scoreboard_pkg::*;

    // entries loaded densely from index zero; the rest of the table only holds the
    // entries that a full-depth search for the smallest or largest key walks through
    localparam int FILL_COUNT = 128;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [SIZE_W-1:0]      i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // entry_index, key, entry_payload, entry_weight, zero fill (from bit 0)
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // action
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // match_index, match_payload, match_weight, zero fill (from bit 0)
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // found
    logic                   m_axis_tuser;

    search_scoreboard sb;
    int unsigned      burst_left = 0;
    int unsigned      settings   = 0;

    sorted_table_key_search #(
        .TABLE_DEPTH (4096)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Offer one request and hold it until taken. Between bursts drop tvalid and idle
    // before the next offer, so tvalid never gets two updates in one time step.
    task automatic send_request(input logic act, input logic [IDX_W-1:0] idx,
                                input logic [KEY_W-1:0] key, input logic [DATA_W-1:0] payload,
                                input logic [DATA_W-1:0] weight);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'b0, weight, payload, key, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(act, idx, key, payload, weight);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 12);
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    // Stop offering and wait until every expected result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Write table_size only with the block idle.
    task automatic set_table_size(input int unsigned value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= SIZE_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_table_size(value);
        settings++;
    endtask

    // Keep every probe on written entries: fall back to the zero key, whose path runs
    // down the low spine that is always loaded.
    task automatic search_for(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] sought;
        sought = sb.path_written(key) ? key : '0;
        send_request(ACT_SEARCH, IDX_W'($urandom), sought, DATA_W'($urandom),
                     DATA_W'($urandom));
    endtask

    // Load ascending keys: a dense run from index zero with duplicates, then strictly
    // rising keys on both search spines of the full table, all ones at the top.
    task automatic fill_sorted_table();
        logic [KEY_W-1:0] key;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        key = '0;
        for (int i = 0; i < FILL_COUNT; i++) begin
            if (i != 0 && $urandom_range(0, 6) != 0) begin
                key = key + ({32'h0, $urandom} << $urandom_range(0, 20));
            end
            send_request(ACT_WRITE, IDX_W'(i), key, DATA_W'($urandom), DATA_W'($urandom));
        end
        for (int unsigned i = 2 * FILL_COUNT - 1; i < MIRROR_DEPTH / 2; i = 2 * i + 1) begin
            key = key + 64'd1 + ({32'h0, $urandom} << $urandom_range(0, 20));
            send_request(ACT_WRITE, IDX_W'(i), key, DATA_W'($urandom), DATA_W'($urandom));
        end
        lo = MIRROR_DEPTH / 2;
        hi = MIRROR_DEPTH - 1;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            key = key + 64'd1 + ({32'h0, $urandom} << $urandom_range(0, 20));
            send_request(ACT_WRITE, IDX_W'(mid), key, DATA_W'($urandom), DATA_W'($urandom));
            lo = mid + 1;
        end
        send_request(ACT_WRITE, IDX_W'(MIRROR_DEPTH - 1), '1, DATA_W'($urandom),
                     DATA_W'($urandom));
    endtask

    // One random request: mostly searches for keys near the live entries, plus writes
    // that mostly keep the order and sometimes break it.
    task automatic random_request();
        int unsigned      n;
        int unsigned      idx;
        int unsigned      pick;
        logic [KEY_W-1:0] key;
        n = sb.effective_size();
        if ($urandom_range(0, 9) < 7) begin
            idx  = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, MIRROR_DEPTH - 1);
            if (!sb.written_mem[idx]) begin
                idx = $urandom_range(0, FILL_COUNT - 1);
            end
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                key = sb.key_mem[idx];
            end else if (pick < 11) begin
                key = sb.key_mem[idx] + 64'd1;
            end else if (pick < 13) begin
                key = sb.key_mem[idx] - 64'd1;
            end else if (pick < 17) begin
                key = {$urandom, $urandom};
            end else if (pick < 18) begin
                key = '0;
            end else begin
                key = '1;
            end
            search_for(key);
        end else begin
            if (n > 0 && $urandom_range(0, 1) == 1) begin
                idx = $urandom_range(0, n - 1);
            end else begin
                idx = $urandom_range(0, MIRROR_DEPTH - 1);
            end
            key = ($urandom_range(0, 19) < 3 || !sb.written_mem[idx]) ? {$urandom, $urandom}
                                                                       : sb.key_mem[idx];
            send_request(ACT_WRITE, IDX_W'(idx), key, DATA_W'($urandom), DATA_W'($urandom));
        end
    endtask

    task automatic random_phase(input int unsigned size, input int unsigned count);
        set_table_size(size);
        repeat (count) random_request();
    endtask

    // Sample results on the rising edge; all drives are nonblocking, so these are the
    // values the block saw at that edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    // Result side: switch at random among four stall patterns, and three times hold off
    // for a long stretch so the block fills and back-pressures the requests.
    initial begin
        int unsigned cyc;
        int unsigned mode;
        int unsigned hold_left;
        int unsigned holds_done;
        cyc        = 0;
        mode       = 0;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 64 == 0) begin
                mode = $urandom_range(0, 3);
            end
            if (hold_left == 0 && sb != null && holds_done < 3
                    && sb.results >= (holds_done == 0 ? 40 : (holds_done == 1 ? 200 : 450))) begin
                hold_left = 250;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                unique case (mode)
                    0: begin
                        m_axis_tready <= 1'b1;
                    end
                    1: begin
                        m_axis_tready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_axis_tready <= (cyc % 4 == 0);
                    end
                    default: begin
                        m_axis_tready <= ($urandom_range(0, 3) != 0);
                    end
                endcase
            end
        end
    end

    initial begin
        #2000000;
        $display("sorted_table_key_search test failed");
        $finish;
    end

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table after reset: not found at index zero, nothing read
        search_for('0);
        search_for('1);
        // write acknowledges with extreme fields, a duplicate key pair
        send_request(ACT_WRITE, 12'd0, 64'd0, 16'hFFFF, 16'h0000);
        send_request(ACT_WRITE, 12'd1, 64'd5, 16'h0000, 16'hFFFF);
        send_request(ACT_WRITE, 12'd2, 64'd5, 16'h1234, 16'h5678);
        send_request(ACT_WRITE, 12'd3, '1, 16'hA5A5, 16'h5A5A);
        send_request(ACT_WRITE, 12'd4095, 64'h8000_0000_0000_0000, 16'hFFFF, 16'hFFFF);
        set_table_size(4);
        search_for(64'd0);
        search_for(64'd5);
        search_for(64'd4);
        search_for(64'd6);
        search_for('1);
        search_for(64'h8000_0000_0000_0000);
        set_table_size(1);
        search_for(64'd0);
        search_for(64'd5);

        fill_sorted_table();

        // oversized table_size saturates to the full depth
        set_table_size(8191);
        search_for('1);
        search_for('0);
        search_for(sb.key_mem[4094]);
        set_table_size(4096);
        search_for('1);
        search_for(sb.key_mem[4094] + 64'd1);

        random_phase(4096, 25);
        random_phase(8191, 25);
        random_phase(1, 30);
        random_phase(2, 30);
        random_phase(3, 30);
        random_phase(4097, 25);
        random_phase(0, 20);
        repeat (3) random_phase($urandom_range(1, 64), 35);
        repeat (2) random_phase($urandom_range(0, FILL_COUNT), 40);
        random_phase(4096, 25);

        // let the last results arrive, then allow for the longest search latency
        drain_results();
        repeat (20) @(posedge i_clk);
        sb.flag_leftovers();

        $display("Covered %0d writes and %0d searches (%0d hits) over %0d table_size settings,",
                 sb.writes, sb.searches, sb.hits, settings);
        $display("including empty, single-entry, full and saturated tables.");
        if (sb.errors == 0) begin
            $display("sorted_table_key_search test passed");
        end else begin
            $display("sorted_table_key_search test failed");
        end
        $finish;
    end

endmodule
